// ===== rtl/bdpc_pkg.sv =====
// Shared types and constants of the block delta pixel codec.
package bdpc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECODE_MODE    = 2'd0,
        CFG_THREE_CHANNELS = 2'd1,
        CFG_BLOCK_WIDTH    = 2'd2
    } cfg_index_t;

    // Pixel and beat widths
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;

    // Block width after reset
    localparam logic [CFG_DATA_W-1:0] BLOCK_WIDTH_RESET = 7'd64;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    // Position flags of one pixel inside its block
    typedef struct packed {
        logic row0;
        logic first;
        logic last;
    } pos_t;

endpackage

// ===== rtl/block_delta_pixel_codec.sv =====
// Top level of the block delta pixel codec: DPCM predictor over a row memory.
//
//  channel | direction | signals                       | payload
//  --------+-----------+-------------------------------+---------------------------------
//  s       | in        | s_tvalid s_tready s_tdata     | chan0_in chan1_in chan2_in
//  m       | out       | m_tvalid m_tready m_tdata     | chan0_out chan1_out chan2_out
//          |           | m_tuser m_tlast               | block_first, block_last
//  cfg     | in        | cfg_we cfg_index cfg_data     | decode_mode three_channels block_width
//
// One pixel per cycle sustained while m is not stalled; an input beat is
// registered in stage 1 with its row memory read, then in the output register.
// The rate is set by the single row memory, read at accept and written when
// the pixel leaves stage 1, and by the left-pixel loop through left_reg.
// Reset clears counters, left pixel and configuration; the row memory is not
// cleared. A stall on m backs up through the output register into s_tready.
module block_delta_pixel_codec #(
    parameter int MAX_BLOCK_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // fields from bit 0: chan0_in, chan1_in, chan2_in
    input  logic [bdpc_pkg::PIXEL_W-1:0]        s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: chan0_out, chan1_out, chan2_out
    output logic [bdpc_pkg::PIXEL_W-1:0]        m_tdata,
    // fields from bit 0: block_first
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bdpc_pkg::*;

    localparam int CW   = (MAX_BLOCK_WIDTH > 2) ? $clog2(MAX_BLOCK_WIDTH) : 1;
    localparam int WW0  = $clog2(MAX_BLOCK_WIDTH + 1);
    localparam int WW   = (WW0 > CFG_DATA_W) ? WW0 : CFG_DATA_W;

    // Configuration registers
    logic                  decode_mode_reg;
    logic                  three_channels_reg;
    logic [CFG_DATA_W-1:0] block_width_reg;

    // Block position counters and left pixel
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    pixel_t        left_reg;

    // Stage 1: pixel waiting on its memory read
    logic          s1_valid_reg;
    pixel_t        s1_x_reg;
    logic [CW-1:0] s1_col_reg;
    pos_t          s1_pos_reg;

    // Row memory and its read and bypass registers
    pixel_t        mem [MAX_BLOCK_WIDTH];
    pixel_t        rd_reg;
    logic          byp_reg;
    pixel_t        byp_data_reg;

    // Output register
    logic          out_valid_reg;
    pixel_t        out_data_reg;
    pos_t          out_pos_reg;

    logic          in_fire;
    logic          s1_adv;
    logic [WW-1:0] bw_ext;
    logic [WW-1:0] bw_eff;
    logic [WW-1:0] last_ext;
    logic [CW-1:0] last;
    logic [CW-1:0] col_eff;
    logic [CW-1:0] row_eff;
    pos_t          pos_in;
    pixel_t        above;
    pixel_t        pred;
    chan_t         x0, x1, x2;
    chan_t         p0, p1, p2;
    chan_t         d0, d1, d2;
    chan_t         r0, r2;
    chan_t         pix0, pix1, pix2;
    chan_t         res0, res1, res2;
    pixel_t        pix;
    pixel_t        res;

    // Handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_fire  = s_tvalid && s_tready;

    // Clamp block width and position, form position flags and next counters
    always_comb
    begin
        bw_ext = WW'(block_width_reg);
        if (bw_ext < WW'(2))
            bw_eff = WW'(2);
        else if (bw_ext > WW'(MAX_BLOCK_WIDTH))
            bw_eff = WW'(MAX_BLOCK_WIDTH);
        else
            bw_eff = bw_ext;
        last_ext = bw_eff - WW'(1);
        last     = last_ext[CW-1:0];
        col_eff  = (col_reg >= last) ? last : col_reg;
        row_eff  = (row_reg >= last) ? last : row_reg;
        pos_in.row0  = (row_eff == '0);
        pos_in.first = (row_reg == '0) && (col_reg == '0);
        pos_in.last  = (row_eff == last) && (col_eff == last);
        if (col_eff == last)
        begin
            col_next = '0;
            row_next = (row_eff == last) ? '0 : row_eff + CW'(1);
        end
        else
        begin
            col_next = col_eff + CW'(1);
            row_next = row_eff;
        end
    end

    // Predict, then form residual or reconstructed pixel
    always_comb
    begin
        above = byp_reg ? byp_data_reg : rd_reg;
        pred  = s1_pos_reg.row0 ? left_reg : above;
        x0 = s1_x_reg[CHAN_W-1:0];
        x1 = three_channels_reg ? s1_x_reg[2*CHAN_W-1:CHAN_W] : '0;
        x2 = three_channels_reg ? s1_x_reg[3*CHAN_W-1:2*CHAN_W] : '0;
        p0 = pred[CHAN_W-1:0];
        p1 = pred[2*CHAN_W-1:CHAN_W];
        p2 = pred[3*CHAN_W-1:2*CHAN_W];
        d0 = x0 - p0;
        d1 = x1 - p1;
        d2 = x2 - p2;
        r0 = three_channels_reg ? x0 + x1 : x0;
        r2 = three_channels_reg ? x2 + x1 : x2;
        if (!decode_mode_reg)
        begin
            pix0 = x0;
            pix1 = x1;
            pix2 = x2;
            if (s1_pos_reg.first)
            begin
                res0 = x0;
                res1 = x1;
                res2 = x2;
            end
            else
            begin
                res0 = three_channels_reg ? d0 - d1 : d0;
                res1 = d1;
                res2 = three_channels_reg ? d2 - d1 : d2;
            end
        end
        else
        begin
            if (s1_pos_reg.first)
            begin
                pix0 = x0;
                pix1 = x1;
                pix2 = x2;
            end
            else
            begin
                pix0 = r0 + p0;
                pix1 = x1 + p1;
                pix2 = r2 + p2;
            end
            res0 = pix0;
            res1 = pix1;
            res2 = pix2;
        end
        if (!three_channels_reg)
        begin
            pix1 = '0;
            pix2 = '0;
            res1 = '0;
            res2 = '0;
        end
        pix = {pix2, pix1, pix0};
        res = {res2, res1, res0};
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg    <= 1'b0;
            three_channels_reg <= 1'b0;
            block_width_reg    <= BLOCK_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECODE_MODE:    decode_mode_reg    <= cfg_data[0];
                CFG_THREE_CHANNELS: three_channels_reg <= cfg_data[0];
                CFG_BLOCK_WIDTH:    block_width_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Control state: counters, stage valids, left pixel, bypass flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                byp_reg <= s1_adv && (s1_col_reg == col_eff);
            end
            if (s1_adv)
                left_reg <= pix;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg     <= s_tdata;
            s1_col_reg   <= col_eff;
            s1_pos_reg   <= pos_in;
            byp_data_reg <= pix;
        end
        if (s1_adv)
        begin
            out_data_reg <= res;
            out_pos_reg  <= s1_pos_reg;
        end
    end

    // Row memory: read at accept, write back when the pixel leaves stage 1
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mem[s1_col_reg] <= pix;
        if (in_fire)
            rd_reg <= mem[col_eff];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_pos_reg.first;
    assign m_tlast  = out_pos_reg.last;

endmodule

// ===== rtl/bdpc_checker.sv =====
// Port-level checker for the block delta pixel codec, bound to the top level.
module bdpc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bdpc_pkg::PIXEL_W-1:0]    m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready
);
    import bdpc_pkg::*;

    logic       in_fire;
    logic       out_fire;
    logic       seen_out_reg;
    logic       after_last_reg;
    logic [1:0] pend_reg, pend_next;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Count items accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
            pend_next = pend_reg + 2'd1;
        else if (out_fire && !in_fire)
            pend_next = pend_reg - 2'd1;
    end

    // Track first beat, beat after a block end and items in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_out_reg   <= 1'b0;
            after_last_reg <= 1'b0;
            pend_reg       <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_fire)
            begin
                seen_out_reg   <= 1'b1;
                after_last_reg <= m_tlast;
            end
        end
    end

    a_first_beat_opens_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !seen_out_reg |-> m_tuser)
        else $error("first beat after reset does not open a block");

    a_block_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && after_last_reg |-> m_tuser)
        else $error("beat after block end does not open a block");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result shown with no item in flight");

    a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more items in flight than stages");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind block_delta_pixel_codec bdpc_checker u_bdpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
